### src/trie_insert_and_lookup_assert.svh
// Assertion macros for the trie RTL.
// Used by the files that check their own logic; no other dependencies.
`ifndef TRIE_INSERT_AND_LOOKUP_ASSERT_SVH
`define TRIE_INSERT_AND_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trie check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trie check failed");

`endif

### src/tpt_pkg.sv
// Package of the trie block: sizes, operation and status codes, shared types.
// No dependencies.
`default_nettype none

package tpt_pkg;

    // Pool and alphabet sizes
    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = $clog2(NODE_COUNT + 1);
    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    // child entry: {end mark of the child, child index}
    localparam int ENTRY_W  = NODE_W + 1;

    localparam int KIND_W   = 2;
    localparam int LETTER_W = 5;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PREFIX = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd3;

    // Child-table port command from the walker
    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  addr;
        logic [ENTRY_W-1:0] wdata;
    } mem_cmd_t;

    // Result handed from the walker to the output register
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

`default_nettype wire

### src/tpt_if.sv
// Handshake channels of the trie block: letter requests in, status results out.
// Depends on tpt_pkg.
`default_nettype none

interface tpt_in_if
    import tpt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;
    logic                last;

    modport source (output valid, output kind, output letter, output last, input ready);
    modport sink   (input valid, input kind, input letter, input last, output ready);
endinterface

interface tpt_out_if
    import tpt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

### src/trie_insert_and_lookup.sv
// Top level of the trie block: walker, child-table RAM and result register.
// Depends on tpt_pkg, tpt_if, tpt_ram and tpt_walk.
`default_nettype none

// Prefix tree over letters a..z in a pool of 1024 nodes, one letter per request.
// Each letter has a read step, which reads the child entry of the current node
// from the child-table RAM, and a look step, which takes the answer and writes
// back a new child or the end mark into the same entry; the next letter needs
// that node, so a request waits until the look step is done and the output
// register is free. A request whose last flag is set has its status formed in
// the look step and registered in the output register. After reset all 26624
// entries are cleared, one per cycle, and no request is accepted meanwhile.
module trie_insert_and_lookup
    import tpt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tpt_in_if.sink    in_chan,
    tpt_out_if.source out_chan
);

    mem_cmd_t            mem_cmd;
    logic [ENTRY_W-1:0]  mem_rdata;
    res_t                res;
    logic                res_free;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;

    tpt_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_chan),
        .res_free  (res_free),
        .res       (res),
        .mem_cmd   (mem_cmd),
        .mem_rdata (mem_rdata)
    );

    tpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_child_ram (
        .clk   (clk),
        .we    (mem_cmd.we),
        .addr  (mem_cmd.addr),
        .wdata (mem_cmd.wdata),
        .rdata (mem_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_free = !out_valid_reg || out_chan.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg <= res.status;
        end
    end

    assign out_chan.valid  = out_valid_reg;
    assign out_chan.status = status_reg;

endmodule

`default_nettype wire

### src/tpt_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read one entry per cycle, and write it too when we is set
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### src/tpt_walk.sv
// Letter walker of the trie: clearing pass, child-table read, allocate and mark.
// Depends on tpt_pkg, tpt_if and the assertion macros.
`default_nettype none
`include "trie_insert_and_lookup_assert.svh"

module tpt_walk
    import tpt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    tpt_in_if.sink            in_chan,
    input  wire logic         res_free,
    output res_t              res,
    output mem_cmd_t          mem_cmd,
    input  wire logic [ENTRY_W-1:0] mem_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic                failed_reg, failed_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [KIND_W-1:0]   kind_reg;
    logic                letter_ok_reg;
    logic                last_reg;
    logic [SLOT_W-1:0]   slot_reg;

    logic                accept;
    logic                letter_ok;
    logic [SLOT_W-1:0]   slot_rd;
    logic [NODE_W-1:0]   child;
    logic                end_bit;
    logic                miss;
    logic                is_ins;
    logic                pool_full;
    logic                fail_now;
    logic                alloc;
    logic                mark;
    logic                end_new;
    logic [NODE_W-1:0]   node_new;
    logic                we_look;
    logic [STATUS_W-1:0] status;

    assign in_chan.ready = (state_reg == S_IDLE) && res_free;
    assign accept        = in_chan.valid && in_chan.ready;

    // slot address of the current node and the incoming letter
    assign letter_ok = (32'(in_chan.letter) < ALPHABET_SIZE);
    assign slot_rd   = SLOT_W'(SLOT_W'(cur_reg) * SLOT_W'(ALPHABET_SIZE))
                     + (letter_ok ? SLOT_W'(in_chan.letter) : '0);

    // decode of the child entry read back
    assign child     = mem_rdata[NODE_W-1:0];
    assign end_bit   = mem_rdata[NODE_W];
    assign miss      = (child == '0);
    assign is_ins    = (kind_reg == KIND_INSERT);
    assign pool_full = (free_reg == FREE_W'(NODE_COUNT));
    assign fail_now  = failed_reg || !letter_ok_reg || (miss && (!is_ins || pool_full));
    assign alloc     = !fail_now && miss;
    assign mark      = is_ins && last_reg;
    assign end_new   = (miss ? 1'b0 : end_bit) | mark;
    assign node_new  = miss ? free_reg[NODE_W-1:0] : child;
    assign we_look   = !fail_now && (miss || (mark && !end_bit));

    // status of a word on its last letter
    always_comb
    begin
        case (kind_reg)
            KIND_INSERT: status = fail_now ? ST_POOL_FULL : ST_INSERTED;
            KIND_SEARCH: status = (!fail_now && end_new) ? ST_FOUND : ST_NOT_FOUND;
            default:     status = fail_now ? ST_NOT_FOUND : ST_FOUND;
        endcase
    end

    assign res.valid  = (state_reg == S_LOOK) && last_reg;
    assign res.status = status;

    // memory port: clear sweep, write-back or lookup read
    always_comb
    begin
        case (state_reg)
            S_CLEAR:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.addr  = clr_cnt_reg;
                mem_cmd.wdata = '0;
            end
            S_LOOK:
            begin
                mem_cmd.we    = we_look;
                mem_cmd.addr  = slot_reg;
                mem_cmd.wdata = {end_new, node_new};
            end
            default:
            begin
                mem_cmd.we    = 1'b0;
                mem_cmd.addr  = slot_rd;
                mem_cmd.wdata = '0;
            end
        endcase
    end

    // sequencer and walk state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        failed_next  = failed_reg;
        free_next    = free_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_W'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_IDLE;
                if (alloc)
                begin
                    free_next = free_reg + 1'b1;
                end
                if (last_reg)
                begin
                    cur_next    = '0;
                    failed_next = 1'b0;
                end
                else
                begin
                    failed_next = fail_now;
                    if (!fail_now)
                    begin
                        cur_next = node_new;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            cur_reg     <= '0;
            failed_reg  <= 1'b0;
            free_reg    <= FREE_W'(1);
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cur_reg     <= cur_next;
            failed_reg  <= failed_next;
            free_reg    <= free_next;
        end
    end

    // captured request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= in_chan.kind;
            letter_ok_reg <= letter_ok;
            last_reg      <= in_chan.last;
            slot_reg      <= slot_rd;
        end
    end

    `TPT_ASSERT_NXT(a_accept_to_look, clk, rst_n, accept, state_reg == S_LOOK)
    `TPT_ASSERT_IMP(a_res_only_last, clk, rst_n, res.valid, last_reg && state_reg == S_LOOK)
    `TPT_ASSERT_NXT(a_alloc_bumps, clk, rst_n, state_reg == S_LOOK && alloc, free_reg == $past(free_reg) + 1'b1)
    `TPT_ASSERT_IMP(a_alloc_in_pool, clk, rst_n, state_reg == S_LOOK && alloc, !pool_full && is_ins)

endmodule

`default_nettype wire

### dv/trie_status_checker.sv
`timescale 1ns / 1ps
// Checker for the trie block: watches both channels, keeps its own copy of
// the prefix tree and compares every status result. Depends on tpt_pkg, tpt_if.

module trie_status_checker
    import tpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tpt_in_if    in_mon,
    tpt_out_if   out_mon,
    output int   fail_count,
    output int   pending
);

    // Shadow copy of the tree and of the walk in progress
    logic [NODE_W-1:0]   child_of [NODE_COUNT][ALPHABET_SIZE];
    bit                  end_mark [NODE_COUNT];
    int unsigned         free_node;
    logic [NODE_W-1:0]   at_node;
    bit                  missed;

    logic [STATUS_W-1:0] status_due [$];
    logic [STATUS_W-1:0] want;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Walk one letter; returns 1 with the status when the letter ends a word
    function automatic bit walk_letter(input logic [KIND_W-1:0] k,
                                       input logic [LETTER_W-1:0] l,
                                       input logic fin,
                                       output logic [STATUS_W-1:0] st);
        logic [NODE_W-1:0] nxt;
        st = ST_NOT_FOUND;
        if (!missed)
        begin
            if (l >= ALPHABET_SIZE)
            begin
                missed = 1'b1;
            end
            else
            begin
                nxt = child_of[at_node][l];
                if (nxt == '0)
                begin
                    // only an insert with room left may grow the tree
                    if (k != KIND_INSERT || free_node >= NODE_COUNT)
                    begin
                        missed = 1'b1;
                    end
                    else
                    begin
                        nxt = free_node[NODE_W-1:0];
                        child_of[at_node][l] = nxt;
                        free_node++;
                    end
                end
                if (!missed)
                    at_node = nxt;
            end
        end
        if (!fin)
            return 1'b0;

        // the kind of the final letter decides the answer
        if (k == KIND_INSERT)
        begin
            if (missed)
            begin
                st = ST_POOL_FULL;
            end
            else
            begin
                end_mark[at_node] = 1'b1;
                st = ST_INSERTED;
            end
        end
        else if (k == KIND_SEARCH)
        begin
            st = (!missed && end_mark[at_node]) ? ST_FOUND : ST_NOT_FOUND;
        end
        else
        begin
            // prefix test, and the unused code behaves the same
            st = missed ? ST_NOT_FOUND : ST_FOUND;
        end
        at_node = '0;
        missed  = 1'b0;
        return 1'b1;
    endfunction

    // Results are checked before new requests are predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NODE_COUNT; n++)
            begin
                end_mark[n] = 1'b0;
                for (int c = 0; c < ALPHABET_SIZE; c++)
                    child_of[n][c] = '0;
            end
            free_node  = 1;
            at_node    = '0;
            missed     = 1'b0;
            status_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (status_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, status %0d",
                                              out_mon.status));
                end
                else
                begin
                    want = status_due.pop_front();
                    if (out_mon.status !== want)
                        report_mismatch($sformatf("status got %0d, want %0d",
                                                  out_mon.status, want));
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (walk_letter(in_mon.kind, in_mon.letter, in_mon.last, want))
                    status_due.push_back(want);
            end
            pending = status_due.size();
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Top of the trie testbench: clock, reset, letter stimulus and result sink.
// Depends on tpt_pkg, tpt_if, the trie RTL and trie_status_checker.

module testbench;
    import tpt_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RUN_LIMIT_NS = 8_000_000;
    localparam int ITEM_TARGET  = 1900;
    localparam int WARMUP_ITEMS = 700;
    localparam int FILL_WORDS   = 80;
    localparam int WORD_MAX     = 32;
    localparam int DICT_MAX     = 512;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam byte LETTER_BASE = "a";
    // code outside the defined operations, handled as a prefix test
    localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   results_seen = 0;
    int   full_seen    = 0;
    int   letters_sent = 0;
    int   send_quiet   = 0;
    int   sink_quiet   = 0;

    // Current word and the words inserted so far
    logic [LETTER_W-1:0] word [WORD_MAX];
    int                  wlen;
    logic [LETTER_W-1:0] dict_letters [DICT_MAX][WORD_MAX];
    int                  dict_len [DICT_MAX];
    int                  dict_n = 0;

    tpt_in_if  in_chan ();
    tpt_out_if out_chan ();

    trie_insert_and_lookup dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    trie_status_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_chan),
        .out_mon    (out_chan),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Result counts steer the back-pressure and the pool fill
    always @(posedge clk)
    begin
        if (out_chan.valid && out_chan.ready)
        begin
            results_seen++;
            if (out_chan.status == ST_POOL_FULL)
                full_seen++;
        end
    end

    // Mostly short gaps, a few long ones, now and then a run with none
    function automatic int pick_gap(ref int quiet);
        int roll;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_letter(input logic [KIND_W-1:0] k,
                               input logic [LETTER_W-1:0] l,
                               input logic fin);
        int gap;
        gap = pick_gap(send_quiet);
        if (gap > 0)
        begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_chan.valid  <= 1'b1;
        in_chan.kind   <= k;
        in_chan.letter <= l;
        in_chan.last   <= fin;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        @(negedge clk);
        letters_sent++;
    endtask

    // Send the current word; with mix set every letter picks its own kind
    task automatic send_word(input logic [KIND_W-1:0] k, input bit mix);
        bit clean;
        clean = 1'b1;
        for (int i = 0; i < wlen; i++)
        begin
            if (word[i] >= ALPHABET_SIZE)
                clean = 1'b0;
            send_letter(mix ? KIND_W'($urandom_range(0, 3)) : k, word[i], i == wlen - 1);
        end
        // keep inserted words around for later searches
        if (k == KIND_INSERT && !mix && clean)
        begin
            if (dict_n < DICT_MAX)
            begin
                dict_letters[dict_n] = word;
                dict_len[dict_n] = wlen;
                dict_n++;
            end
            else
            begin
                int slot;
                slot = $urandom_range(0, DICT_MAX - 1);
                dict_letters[slot] = word;
                dict_len[slot] = wlen;
            end
        end
    endtask

    task automatic send_text(input logic [KIND_W-1:0] k, input string s);
        wlen = s.len();
        for (int i = 0; i < wlen; i++)
            word[i] = LETTER_W'(s[i] - LETTER_BASE);
        send_word(k, 1'b0);
    endtask

    task automatic grow_word(input int n, input int top_letter);
        for (int i = 0; i < n && wlen < WORD_MAX; i++)
        begin
            word[wlen] = LETTER_W'($urandom_range(0, top_letter));
            wlen++;
        end
    endtask

    task automatic load_known();
        int pick;
        pick = $urandom_range(0, dict_n - 1);
        word = dict_letters[pick];
        wlen = dict_len[pick];
    endtask

    // One random word: mostly walks along known words, some fresh, some noise
    task automatic random_word();
        int roll;
        int twist;
        logic [KIND_W-1:0] k;
        bit mix;
        roll = $urandom_range(0, 99);
        mix = 1'b0;
        if (roll < 30)
        begin
            k = KIND_INSERT;
            if (dict_n > 0 && $urandom_range(0, 1) == 1)
            begin
                // branch off somewhere along a known word
                load_known();
                wlen = $urandom_range(1, wlen);
                grow_word($urandom_range(0, 4), $urandom_range(2, 25));
            end
            else
            begin
                wlen = 0;
                grow_word($urandom_range(1, 8), $urandom_range(2, 25));
            end
        end
        else if (roll < 75)
        begin
            k = (roll < 55) ? KIND_SEARCH : KIND_PREFIX;
            if (dict_n > 0)
            begin
                load_known();
                twist = $urandom_range(0, 3);
                if (twist == 0)
                    wlen = $urandom_range(1, wlen);
                else if (twist == 1)
                    word[$urandom_range(0, wlen - 1)] = LETTER_W'($urandom_range(0, 25));
                else if (twist == 2)
                    grow_word($urandom_range(1, 2), 25);
            end
            else
            begin
                wlen = 0;
                grow_word($urandom_range(1, 4), 25);
            end
        end
        else if (roll < 85)
        begin
            k = $urandom_range(0, 1) ? KIND_SEARCH : KIND_PREFIX;
            wlen = 0;
            grow_word($urandom_range(1, 6), $urandom_range(2, 25));
        end
        else
        begin
            // noise: any code, letters past z, kinds mixed inside the word
            k = KIND_W'($urandom_range(0, 3));
            mix = 1'($urandom_range(0, 1));
            wlen = 0;
            grow_word($urandom_range(1, 6), 31);
        end
        send_word(k, mix);
    endtask

    // Stimulus
    initial
    begin : letter_source
        int full_mark;
        int fill_count;
        rst_n          = 1'b0;
        in_chan.valid  = 1'b0;
        in_chan.kind   = KIND_INSERT;
        in_chan.letter = '0;
        in_chan.last   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty tree, first words, letters at both ends of the alphabet
        send_text(KIND_SEARCH, "a");
        send_text(KIND_PREFIX, "z");
        send_text(KIND_INSERT, "a");
        send_text(KIND_SEARCH, "a");
        send_text(KIND_INSERT, "zz");
        send_text(KIND_PREFIX, "z");
        send_text(KIND_SEARCH, "z");
        send_text(KIND_UNDEF, "zz");
        // letters past z fail the walk
        send_letter(KIND_INSERT, LETTER_W'(1), 1'b0);
        send_letter(KIND_INSERT, LETTER_W'(31), 1'b1);
        send_letter(KIND_SEARCH, LETTER_W'(26), 1'b1);
        // after a miss the rest of the word does not move
        send_letter(KIND_PREFIX, LETTER_W'(16), 1'b0);
        send_letter(KIND_PREFIX, LETTER_W'(0), 1'b1);
        // mixed kinds: the final letter decides
        send_letter(KIND_INSERT, LETTER_W'(2), 1'b0);
        send_letter(KIND_SEARCH, LETTER_W'(3), 1'b1);
        send_letter(KIND_SEARCH, LETTER_W'(25), 1'b0);
        send_letter(KIND_INSERT, LETTER_W'(0), 1'b1);
        send_text(KIND_SEARCH, "za");

        while (letters_sent < WARMUP_ITEMS)
            random_word();

        // long fresh inserts until the pool runs out
        in_chan.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        full_mark = full_seen;
        fill_count = 0;
        while (full_seen == full_mark && fill_count < FILL_WORDS)
        begin
            wlen = 0;
            grow_word($urandom_range(16, 24), 25);
            send_word(KIND_INSERT, 1'b0);
            fill_count++;
        end

        // full pool: known paths still work, new ones fail
        while (letters_sent < ITEM_TARGET)
            random_word();

        in_chan.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result sink, with one long hold-off so the block backs up
    initial
    begin : result_sink
        int stall;
        int open_len;
        bit held;
        held = 1'b0;
        out_chan.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AT)
            begin
                held = 1'b1;
                out_chan.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = pick_gap(sink_quiet);
            if (stall > 0)
            begin
                out_chan.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_chan.ready <= 1'b1;
            open_len = $urandom_range(1, 6);
            repeat (open_len) @(negedge clk);
        end
    end

    initial
    begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/tpt_pkg.sv
src/tpt_if.sv
src/tpt_ram.sv
src/tpt_walk.sv
src/trie_insert_and_lookup.sv
dv/trie_status_checker.sv
dv/testbench.sv
